// ===== rtl/cap_pkg.sv =====
// package for the clipped alpha pixel writer
// holds field widths, blend constants, register index codes and the config struct
// no dependencies
package cap_pkg;

    // fixed field widths
    localparam int CFG_W       = 13;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 32;
    localparam int INDEX_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int MIX_W       = 2 * CHAN_W;
    localparam int CFG_IDX_W   = 2;
    localparam int DEF_MAX_DIM = 4096;

    // alpha codes treated as opaque
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // divide by 255 as multiply by ceil(2^23/255) and shift, exact for sums up to 255*255
    localparam int                RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_255  = 17'd32897;
    localparam int                RECIP_SHIFT = 23;
    localparam int                QUOT_W      = MIX_W + RECIP_W;

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2,
        REG_PITCH   = 2'd3
    } t_cfg_reg;

    // configuration registers as one group
    typedef struct packed {
        logic             enabled;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] pitch;
    } t_cfg;

endpackage

// ===== rtl/cap_addr.sv =====
// clipping test and pixel index for the clipped alpha pixel writer
// registers the clip result and the row product, then adds the column
// depends on cap_pkg
module cap_addr #(
    parameter int MAX_DIM = cap_pkg::DEF_MAX_DIM
) (
    input  logic                                i_clk,
    input  logic                                i_adv,
    input  cap_pkg::t_cfg                       i_cfg,
    input  logic signed [cap_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [cap_pkg::COORD_W-1:0]  i_pos_y,
    output logic                                o_hit,
    output logic        [cap_pkg::INDEX_W-1:0]  o_index
);
    import cap_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int PROD_W = 2 * DIM_W;
    localparam int SUM_W  = (PROD_W + 1 > INDEX_W) ? PROD_W + 1 : INDEX_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DIM);

    // limit a dimension register to the largest supported size
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        return (ext > MAX_C) ? MAX_C[DIM_W-1:0] : ext[DIM_W-1:0];
    endfunction

    logic [DIM_W-1:0]   w_width;
    logic [DIM_W-1:0]   w_height;
    logic [DIM_W-1:0]   w_pitch;
    logic [COORD_W-1:0] w_width_ext;
    logic [COORD_W-1:0] w_height_ext;
    logic               n_hit;
    logic [PROD_W-1:0]  n_prod;
    logic [DIM_W-1:0]   n_col;
    logic               r_hit;
    logic [PROD_W-1:0]  r_prod;
    logic [DIM_W-1:0]   r_col;
    logic [SUM_W-1:0]   w_sum;

    // clamped dimensions
    always_comb begin
        w_width      = clamp_dim(i_cfg.width);
        w_height     = clamp_dim(i_cfg.height);
        w_pitch      = clamp_dim(i_cfg.pitch);
        w_width_ext  = COORD_W'(w_width);
        w_height_ext = COORD_W'(w_height);
    end

    // clip test and row offset; coordinates fit DIM_W bits once inside the area
    always_comb begin
        n_hit  = i_cfg.enabled
              && !i_pos_x[COORD_W-1] && !i_pos_y[COORD_W-1]
              && ($unsigned(i_pos_x) < w_width_ext)
              && ($unsigned(i_pos_y) < w_height_ext);
        n_prod = PROD_W'(i_pos_y[DIM_W-1:0]) * PROD_W'(w_pitch);
        n_col  = i_pos_x[DIM_W-1:0];
    end

    // middle stage registers
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hit  <= n_hit;
            r_prod <= n_prod;
            r_col  <= n_col;
        end
    end

    // index keeps the low bits of row offset plus column
    assign w_sum   = SUM_W'(r_prod) + SUM_W'(r_col);
    assign o_hit   = r_hit;
    assign o_index = w_sum[INDEX_W-1:0];

endmodule

// ===== rtl/cap_blend.sv =====
// per-channel alpha blend for the clipped alpha pixel writer
// registers the weighted channel sums, then divides each by 255 and picks the value
// depends on cap_pkg
module cap_blend (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  logic [cap_pkg::COLOR_W-1:0]   i_src_color,
    input  logic [cap_pkg::COLOR_W-1:0]   i_background,
    output logic [cap_pkg::COLOR_W-1:0]   o_value
);
    import cap_pkg::*;

    logic [CHAN_W-1:0]  w_alpha;
    logic [CHAN_W-1:0]  w_alpha_inv;
    logic               n_opaque;
    logic               r_opaque;
    logic [COLOR_W-1:0] r_color;
    logic [MIX_W-1:0]   n_mix [NUM_CHAN];
    logic [MIX_W-1:0]   r_mix [NUM_CHAN];
    logic [QUOT_W-1:0]  w_quot [NUM_CHAN];
    logic [CHAN_W-1:0]  w_chan [NUM_CHAN];

    // alpha of zero or full counts as opaque
    assign w_alpha     = i_src_color[COLOR_W-1 -: CHAN_W];
    assign w_alpha_inv = ALPHA_OPAQUE - w_alpha;
    assign n_opaque    = (w_alpha == ALPHA_CLEAR) || (w_alpha == ALPHA_OPAQUE);

    // weighted sum per channel, divide by 255 after the register
    for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
        assign n_mix[k] = MIX_W'(w_alpha) * MIX_W'(i_src_color[k*CHAN_W +: CHAN_W])
                        + MIX_W'(w_alpha_inv) * MIX_W'(i_background[k*CHAN_W +: CHAN_W]);

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_mix[k] <= n_mix[k];
            end
        end

        assign w_quot[k] = (QUOT_W'(r_mix[k]) * QUOT_W'(RECIP_255)) >> RECIP_SHIFT;
        assign w_chan[k] = w_quot[k][CHAN_W-1:0];
    end

    // color and opaque flag ride along
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_opaque <= n_opaque;
            r_color  <= i_src_color;
        end
    end

    // opaque keeps the color with its alpha byte, blended stores a zero alpha byte
    assign o_value = r_opaque ? r_color : {ALPHA_CLEAR, w_chan[2], w_chan[1], w_chan[0]};

endmodule

// ===== rtl/clipped_alpha_pixel_writer.sv =====
// top level of the clipped alpha pixel writer
// holds the config registers, input and result registers and stall control
// depends on cap_pkg, cap_addr, cap_blend
//
// Takes one pixel draw request per clock unless the master side stalls, and
// returns exactly one result per request, in order. A request is clipped
// against the visible width and height (values above MAX_DIM act as MAX_DIM)
// and dropped when the block is disabled; a dropped request still returns a
// result with all fields zero. A visible pixel gets the index y*row_pitch+x
// (low 24 bits) and either the color as given (alpha 0 or 255) or the
// per-channel blend (a*fg+(255-a)*bg)/255 with a zero alpha byte. Throughput
// is one request per cycle while m_axis_tready stays high. A request passes
// three register stages: the input register, the register after the row and
// blend multipliers, and the result register. Config writes take effect at
// the next edge and should be made only while no request is in flight.
module clipped_alpha_pixel_writer #(
    parameter int MAX_DIM = cap_pkg::DEF_MAX_DIM
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request: pos_x[15:0], pos_y[31:16], src_color[63:32], background[95:64]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [95:0]                      s_axis_tdata,
    // result: pixel_index[23:0], pixel_value[55:24]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [55:0]                      m_axis_tdata,
    // result: write_enable[0]
    output logic                             m_axis_tuser,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [cap_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cap_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import cap_pkg::*;

    t_cfg                       r_cfg;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       w_rdy1;
    logic                       w_rdy2;
    logic                       w_rdy3;
    logic signed [COORD_W-1:0]  r_pos_x;
    logic signed [COORD_W-1:0]  r_pos_y;
    logic [COLOR_W-1:0]         r_src_color;
    logic [COLOR_W-1:0]         r_background;
    logic                       w_hit;
    logic [INDEX_W-1:0]         w_index;
    logic [COLOR_W-1:0]         w_value;
    logic                       n_we;
    logic [INDEX_W-1:0]         n_index;
    logic [COLOR_W-1:0]         n_value;
    logic                       r_we;
    logic [INDEX_W-1:0]         r_index;
    logic [COLOR_W-1:0]         r_value;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_ENABLED: r_cfg.enabled <= i_cfg_wdata[0];
                REG_WIDTH:   r_cfg.width   <= i_cfg_wdata;
                REG_HEIGHT:  r_cfg.height  <= i_cfg_wdata;
                REG_PITCH:   r_cfg.pitch   <= i_cfg_wdata;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    assign w_rdy3        = !r_v3 || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_pos_x      <= s_axis_tdata[15:0];
            r_pos_y      <= s_axis_tdata[31:16];
            r_src_color  <= s_axis_tdata[63:32];
            r_background <= s_axis_tdata[95:64];
        end
    end

    cap_addr #(
        .MAX_DIM (MAX_DIM)
    ) u_addr (
        .i_clk   (i_clk),
        .i_adv   (w_rdy2),
        .i_cfg   (r_cfg),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .o_hit   (w_hit),
        .o_index (w_index)
    );

    cap_blend u_blend (
        .i_clk        (i_clk),
        .i_adv        (w_rdy2),
        .i_src_color  (r_src_color),
        .i_background (r_background),
        .o_value      (w_value)
    );

    // clipped or disabled results carry all zeros
    always_comb begin
        n_we    = w_hit;
        n_index = w_hit ? w_index : '0;
        n_value = w_hit ? w_value : '0;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_we    <= n_we;
            r_index <= n_index;
            r_value <= n_value;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tuser  = r_we;
    assign m_axis_tdata  = {r_value, r_index};

endmodule

// ===== dv/clipped_alpha_pixel_writer_tb.sv =====
// testbench for the clipped alpha pixel writer: directed table then random phases
// predicts clipping, index and blend per request and checks every result in order
// depends on cap_pkg and the clipped_alpha_pixel_writer top level
module clipped_alpha_pixel_writer_tb;

    import cap_pkg::*;

    localparam int MAX_DIM     = DEF_MAX_DIM;
    localparam int CHAN_MAX    = 255;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 125;
    localparam int LONG_HOLD   = 100;
    localparam int DRAIN_WAIT  = 8;

    // one result as seen on the master side
    typedef struct packed {
        logic               we;
        logic [INDEX_W-1:0] idx;
        logic [COLOR_W-1:0] val;
    } t_pixel_write;

    typedef enum logic {
        ROW_PIXEL  = 1'b0,
        ROW_CONFIG = 1'b1
    } t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind          kind;
        t_cfg_reg           reg_idx;
        logic [CFG_W-1:0]   reg_data;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] bg;
        logic               has_exp;
        t_pixel_write       exp;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [95:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [55:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    // register copy used by the predictor
    logic             cfg_enabled;
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic [CFG_W-1:0] cfg_pitch;

    t_pixel_write pending_writes[$];
    t_dir_row     dir_rows[$];

    int  mismatch_count = 0;
    int  request_count  = 0;
    int  written_count  = 0;
    int  dropped_count  = 0;
    int  cfg_writes     = 0;
    int  long_holds     = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;
    bit  long_hold_req  = 1'b0;

    always #1 i_clk = ~i_clk;

    clipped_alpha_pixel_writer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    function automatic int clamp_dim(input int v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    // expected write for one request under the current register copy
    function automatic t_pixel_write predict_write(input logic signed [COORD_W-1:0] x,
                                                   input logic signed [COORD_W-1:0] y,
                                                   input logic [COLOR_W-1:0] color,
                                                   input logic [COLOR_W-1:0] bg);
        int xi;
        int yi;
        int w;
        int h;
        int p;
        int a;
        int fg;
        int bk;
        int mix;
        t_pixel_write r;
        xi = int'(x);
        yi = int'(y);
        w  = clamp_dim(int'(cfg_width));
        h  = clamp_dim(int'(cfg_height));
        p  = clamp_dim(int'(cfg_pitch));
        r  = '0;
        if (cfg_enabled && xi >= 0 && yi >= 0 && xi < w && yi < h) begin
            r.we  = 1'b1;
            r.idx = INDEX_W'(yi * p + xi);
            a     = int'(color[31:24]);
            if (color[31:24] == ALPHA_CLEAR || color[31:24] == ALPHA_OPAQUE) begin
                r.val = color;
            end else begin
                // per channel blend, alpha byte of the result stays zero
                for (int ch = 0; ch < NUM_CHAN; ch++) begin
                    fg  = int'(color[ch*CHAN_W +: CHAN_W]);
                    bk  = int'(bg[ch*CHAN_W +: CHAN_W]);
                    mix = (a * fg + (CHAN_MAX - a) * bk) / CHAN_MAX;
                    r.val[ch*CHAN_W +: CHAN_W] = mix[CHAN_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom_range(1, 16);
        if (r < 55) return $urandom_range(17, 640);
        if (r < 70) return MAX_DIM;
        if (r < 80) return $urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1);
        if (r < 90) return $urandom_range(0, (1 << CFG_W) - 1);
        return 1;
    endfunction

    // coordinate biased toward the visible range and its edges
    function automatic logic [COORD_W-1:0] draw_coord(input int lim);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 65)      v = $urandom_range(0, lim);
        else if (r < 75) v = -$urandom_range(1, 4);
        else if (r < 88) v = lim - 1 + $urandom_range(0, 2);
        else             v = $urandom_range(0, (1 << COORD_W) - 1);
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] draw_color();
        logic [CHAN_W-1:0] a;
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)      a = ALPHA_CLEAR;
        else if (r < 40) a = ALPHA_OPAQUE;
        else if (r < 45) a = 8'd1;
        else if (r < 50) a = 8'd254;
        else             a = CHAN_W'($urandom_range(0, CHAN_MAX));
        return {a, 24'($urandom)};
    endfunction

    task automatic report_mismatch(input string what, input logic [COLOR_W-1:0] got,
                                   input logic [COLOR_W-1:0] exp);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp);
        mismatch_count++;
    endtask

    // lower the request and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_ENABLED: cfg_enabled = data[0];
            REG_WIDTH:   cfg_width   = data;
            REG_HEIGHT:  cfg_height  = data;
            REG_PITCH:   cfg_pitch   = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one request and record its expected write once accepted
    task automatic send_request(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COLOR_W-1:0] color,
                                input logic [COLOR_W-1:0] bg,
                                input logic use_fixed, input t_pixel_write fixed);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bg, color, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_writes.push_back(use_fixed ? fixed : predict_write(x, y, color, bg));
        request_count++;
    endtask

    task automatic add_config(input t_cfg_reg idx, input int data);
        t_dir_row row;
        row          = '0;
        row.kind     = ROW_CONFIG;
        row.reg_idx  = idx;
        row.reg_data = data[CFG_W-1:0];
        dir_rows.push_back(row);
    endtask

    task automatic add_pixel(input int x, input int y, input logic [COLOR_W-1:0] color,
                             input logic [COLOR_W-1:0] bg, input logic has_exp,
                             input logic we, input logic [INDEX_W-1:0] idx,
                             input logic [COLOR_W-1:0] val);
        t_dir_row row;
        row         = '0;
        row.kind    = ROW_PIXEL;
        row.x       = x[COORD_W-1:0];
        row.y       = y[COORD_W-1:0];
        row.color   = color;
        row.bg      = bg;
        row.has_exp = has_exp;
        row.exp     = '{we, idx, val};
        dir_rows.push_back(row);
    endtask

    task automatic configure(input logic en, input int w, input int h, input int p);
        write_reg(REG_ENABLED, {12'($urandom), en});
        write_reg(REG_WIDTH, w[CFG_W-1:0]);
        write_reg(REG_HEIGHT, h[CFG_W-1:0]);
        write_reg(REG_PITCH, p[CFG_W-1:0]);
    endtask

    // result checker, compares against the oldest expectation
    always @(posedge i_clk) begin
        t_pixel_write e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch("result with no request waiting, value", m_axis_tdata[55:24],
                                '0);
            end else begin
                e = pending_writes.pop_front();
                if (m_axis_tuser !== e.we)
                    report_mismatch("write_enable", COLOR_W'(m_axis_tuser), COLOR_W'(e.we));
                if (m_axis_tdata[23:0] !== e.idx)
                    report_mismatch("pixel_index", COLOR_W'(m_axis_tdata[23:0]),
                                    COLOR_W'(e.idx));
                if (m_axis_tdata[55:24] !== e.val)
                    report_mismatch("pixel_value", m_axis_tdata[55:24], e.val);
                if (e.we) written_count++;
                else      dropped_count++;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                long_holds++;
                hold_left     = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
                hold_left     = pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main stimulus
    initial begin
        t_dir_row     row;
        t_pixel_write none;
        int           w;
        int           h;
        int           p;
        logic         en;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_ENABLED;
        i_cfg_wdata   = '0;
        cfg_enabled   = 1'b0;
        cfg_width     = '0;
        cfg_height    = '0;
        cfg_pitch     = '0;
        none          = '0;

        // after reset everything is dropped
        add_pixel(0, 0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        add_pixel(-32768, 32767, 32'h8012_3456, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0);
        // enabled with zero width still clips
        add_config(REG_ENABLED, 1);
        add_pixel(0, 0, 32'hFF00_00FF, 32'h0, 1'b1, 1'b0, '0, '0);
        // full size surface, corners and just outside
        add_config(REG_WIDTH, MAX_DIM);
        add_config(REG_HEIGHT, MAX_DIM);
        add_config(REG_PITCH, MAX_DIM);
        add_pixel(0, 0, 32'hFF12_3456, 32'h0, 1'b1, 1'b1, '0, 32'hFF12_3456);
        add_pixel(4095, 4095, 32'h00AB_CDEF, 32'h0, 1'b1, 1'b1, 24'hFF_FFFF, 32'h00AB_CDEF);
        add_pixel(4096, 0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        add_pixel(0, 4096, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        add_pixel(-1, 0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        add_pixel(0, -1, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        add_pixel(32767, 32767, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        add_pixel(-32768, -32768, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        // blends: mid alpha, near-clear, near-opaque, background alpha ignored
        add_pixel(10, 20, 32'h80FF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0, '0);
        add_pixel(11, 20, 32'h01FF_8000, 32'h0000_FFFF, 1'b0, 1'b0, '0, '0);
        add_pixel(12, 20, 32'hFE12_34FF, 32'hFFFF_FF00, 1'b0, 1'b0, '0, '0);
        add_pixel(13, 21, 32'h7F40_80C0, 32'hFF10_2030, 1'b0, 1'b0, '0, '0);
        // oversized registers act as the maximum
        add_config(REG_WIDTH, 8191);
        add_config(REG_HEIGHT, 8191);
        add_config(REG_PITCH, 8191);
        add_pixel(4095, 4095, 32'hFF00_FF00, 32'h0, 1'b1, 1'b1, 24'hFF_FFFF, 32'hFF00_FF00);
        add_pixel(4096, 4095, 32'hFF00_FF00, 32'h0, 1'b1, 1'b0, '0, '0);
        // single pixel surface with zero pitch
        add_config(REG_WIDTH, 1);
        add_config(REG_HEIGHT, 1);
        add_config(REG_PITCH, 0);
        add_pixel(0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, '0, 32'h0);
        add_pixel(1, 0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        add_pixel(0, 1, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);
        // disabled again
        add_config(REG_ENABLED, 0);
        add_pixel(0, 0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CONFIG) begin
                drain();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_request(row.x, row.y, row.color, row.bg, row.has_exp, row.exp);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            en = ($urandom_range(0, 99) < 85);
            w  = (ph == 0) ? MAX_DIM : pick_dim();
            h  = (ph == 0) ? MAX_DIM : pick_dim();
            p  = (ph == 1) ? 8191 : pick_dim();
            configure(en, w, h, p);
            tx_idle_on = (ph % 3 != 2);
            rx_idle_on = (ph % 4 != 3);
            // receiver holds off while the sender keeps offering
            if (ph == 3) begin
                tx_idle_on    = 1'b0;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender pause until everything is back
                if (ph % 4 == 1 && n == 60) drain();
                send_request(draw_coord(clamp_dim(w)), draw_coord(clamp_dim(h)),
                             draw_color(), $urandom, 1'b0, none);
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d requests: %0d written, %0d clipped or disabled",
                 request_count, written_count, dropped_count);
        $display("%0d register writes, %0d long receiver hold-offs, %0d mismatches",
                 cfg_writes, long_holds, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
